### rtl/gslqr_pkg.sv
// ----------------------------------------------------------------------------
// gslqr_pkg
// Shared types, constants and helpers for the gain-scheduled LQR controller.
// ----------------------------------------------------------------------------
`default_nettype none

package gslqr_pkg;

    // Gain polynomial order, output rows and state columns
    localparam int POLY_ORDER   = 3;
    localparam int NUM_OUTPUTS  = 2;
    localparam int NUM_STATES   = 4;
    localparam int STATE_INPUTS = 4;

    // Coefficient store
    localparam int STORE_DEPTH = 32;
    localparam int STORE_W     = 32;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SLOT_CNT    = NUM_OUTPUTS * NUM_STATES * (POLY_ORDER + 1);
    localparam int SLOT_W      = (SLOT_CNT > STORE_DEPTH) ? $clog2(SLOT_CNT + 1) : ADDR_W + 1;

    // Sequencer counters
    localparam int ROW_W = $clog2(NUM_OUTPUTS + 1);
    localparam int COL_W = $clog2(NUM_STATES + 1);
    localparam int K_W   = $clog2(POLY_ORDER + 2);

    // Datapath widths
    localparam int DATA_W = 32;
    localparam int PROD_W = 64;
    localparam int FLR_W  = PROD_W - 16;
    localparam int ACC_W  = FLR_W + $clog2(NUM_STATES + 1);

    // Stream payload layout
    localparam int S_TDATA_W = 200;
    localparam int M_TDATA_W = 64;
    localparam int OFS_COEF_INDEX  = 0;
    localparam int OFS_COEF_VALUE  = 5;
    localparam int OFS_LEG_LENGTH  = 37;
    localparam int OFS_STATE0      = 69;

    // Configuration registers
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEG_MID      = 2'd0,
        CFG_LEG_HALF     = 2'd1,
        CFG_LEG_HALF_INV = 2'd2
    } cfg_idx_t;

    localparam logic [31:0] LEG_MID_RST      = 32'd0;
    localparam logic [30:0] LEG_HALF_RST     = 31'd65536;
    localparam logic [30:0] LEG_HALF_INV_RST = 31'd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_NORM_MUL,
        ST_NORM_SAT,
        ST_COEF_RD,
        ST_V_INIT,
        ST_HMUL,
        ST_HADD,
        ST_XMUL,
        ST_XACC,
        ST_ROW_END,
        ST_OUT
    } state_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < 64'shFFFF_FFFF_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/gslqr_ram.sv
// ----------------------------------------------------------------------------
// gslqr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gslqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

### rtl/gain_scheduled_lqr_controller_top.sv
// ----------------------------------------------------------------------------
// gain_scheduled_lqr_controller_top
// Gain-scheduled LQR state feedback: clamps and normalizes the leg length,
// evaluates each gain as a Horner polynomial over stored coefficients and
// drives -K*x, saturated, Q16.16. One shared 32x32 multiplier under an FSM.
// ----------------------------------------------------------------------------
// channel | dir | handshake                    | payload
// s_axis  | in  | s_axis_tvalid/s_axis_tready  | tuser: action; tdata: index, value,
//         |     |                              |   leg_length, four states
// m_axis  | out | m_axis_tvalid/m_axis_tready  | tdata: wheel_accel, leg_torque
// cfg     | in  | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// Load request: written to the coefficient RAM on accept.
// Compute request: runs through the FSM on the single multiplier and RAM port
// from accept to result.
// s_axis_tready is low while a compute runs; a pending result waits in the
// output register and does not block the next request.
// aresetn is synchronous; coefficients are not cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gain_scheduled_lqr_controller_top (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [4:0] coef_index, [36:5] coef_value, [68:37] leg_length,
    // [100:69] pitch_angle, [132:101] pitch_rate, [164:133] wheel_angle,
    // [196:165] wheel_rate, [199:197] unused
    input  wire logic [gslqr_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // [0] action
    input  wire logic                                  s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [31:0] wheel_accel, [63:32] leg_torque
    output logic      [gslqr_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [gslqr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [31:0]                           cfg_data
);

    gslqr_pkg::state_t state_reg, state_next;

    logic signed [31:0] leg_mid_reg;
    logic        [30:0] leg_half_reg;
    logic        [30:0] leg_half_inv_reg;

    logic signed [31:0] len_reg;
    logic signed [31:0] x_reg [gslqr_pkg::STATE_INPUTS];
    logic signed [31:0] d_reg;
    logic signed [31:0] u_reg;
    logic signed [31:0] v_reg;
    logic signed [gslqr_pkg::PROD_W-1:0] prod_reg;
    logic signed [gslqr_pkg::ACC_W-1:0]  acc_reg;
    logic signed [31:0] res0_reg;
    logic signed [31:0] res1_reg;
    logic [gslqr_pkg::SLOT_W-1:0] slot_reg;
    logic                         oob_reg;
    logic [gslqr_pkg::ROW_W-1:0]  row_reg;
    logic [gslqr_pkg::COL_W-1:0]  col_reg;
    logic [gslqr_pkg::K_W-1:0]    k_reg;
    logic                         m_valid_reg;
    logic [gslqr_pkg::M_TDATA_W-1:0] m_data_reg;

    logic s_accept, load_req, comp_req;
    logic k_last, col_last, row_last;
    logic out_load;
    logic signed [31:0] mul_a, mul_b;
    logic signed [gslqr_pkg::PROD_W-1:0] mul_p;
    logic signed [gslqr_pkg::FLR_W-1:0]  prod_flr;
    logic signed [31:0] x_sel;
    logic signed [31:0] coef_rd;
    logic [31:0]        ram_rdata;
    logic signed [32:0] diff;
    logic signed [32:0] half_s;
    logic signed [32:0] diff_cl;
    logic signed [gslqr_pkg::FLR_W:0] hsum;
    logic signed [gslqr_pkg::ACC_W:0] acc_neg;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign load_req = s_accept && s_axis_tuser;
    assign comp_req = s_accept && !s_axis_tuser;

    assign k_last   = (k_reg == gslqr_pkg::K_W'(gslqr_pkg::POLY_ORDER));
    assign col_last = (col_reg == gslqr_pkg::COL_W'(gslqr_pkg::NUM_STATES - 1));
    assign row_last = (row_reg == gslqr_pkg::ROW_W'(gslqr_pkg::NUM_OUTPUTS - 1));

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leg_mid_reg      <= gslqr_pkg::LEG_MID_RST;
            leg_half_reg     <= gslqr_pkg::LEG_HALF_RST;
            leg_half_inv_reg <= gslqr_pkg::LEG_HALF_INV_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                gslqr_pkg::CFG_LEG_MID:      leg_mid_reg      <= cfg_data;
                gslqr_pkg::CFG_LEG_HALF:     leg_half_reg     <= cfg_data[30:0];
                gslqr_pkg::CFG_LEG_HALF_INV: leg_half_inv_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // coefficient store
    gslqr_ram #(
        .WIDTH(gslqr_pkg::STORE_W),
        .DEPTH(gslqr_pkg::STORE_DEPTH)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (load_req),
        .waddr (s_axis_tdata[gslqr_pkg::OFS_COEF_INDEX +: gslqr_pkg::ADDR_W]),
        .wdata (s_axis_tdata[gslqr_pkg::OFS_COEF_VALUE +: 32]),
        .raddr (slot_reg[gslqr_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign coef_rd = oob_reg ? 32'sd0 : $signed(ram_rdata);

    // state column select; columns past the inputs read zero
    always_comb begin
        x_sel = 32'sd0;
        for (int n = 0; n < gslqr_pkg::STATE_INPUTS; n++) begin
            if (n < gslqr_pkg::NUM_STATES && col_reg == gslqr_pkg::COL_W'(n)) begin
                x_sel = x_reg[n];
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gslqr_pkg::ST_IDLE:     if (comp_req) state_next = gslqr_pkg::ST_CLAMP;
            gslqr_pkg::ST_CLAMP:    state_next = gslqr_pkg::ST_NORM_MUL;
            gslqr_pkg::ST_NORM_MUL: state_next = gslqr_pkg::ST_NORM_SAT;
            gslqr_pkg::ST_NORM_SAT: state_next = gslqr_pkg::ST_COEF_RD;
            gslqr_pkg::ST_COEF_RD:  state_next = gslqr_pkg::ST_V_INIT;
            gslqr_pkg::ST_V_INIT: begin
                if (gslqr_pkg::POLY_ORDER == 0) state_next = gslqr_pkg::ST_XMUL;
                else                            state_next = gslqr_pkg::ST_HMUL;
            end
            gslqr_pkg::ST_HMUL:     state_next = gslqr_pkg::ST_HADD;
            gslqr_pkg::ST_HADD: begin
                if (k_last) state_next = gslqr_pkg::ST_XMUL;
                else        state_next = gslqr_pkg::ST_HMUL;
            end
            gslqr_pkg::ST_XMUL:     state_next = gslqr_pkg::ST_XACC;
            gslqr_pkg::ST_XACC: begin
                if (col_last) state_next = gslqr_pkg::ST_ROW_END;
                else          state_next = gslqr_pkg::ST_COEF_RD;
            end
            gslqr_pkg::ST_ROW_END: begin
                if (row_last) state_next = gslqr_pkg::ST_OUT;
                else          state_next = gslqr_pkg::ST_COEF_RD;
            end
            gslqr_pkg::ST_OUT:      if (out_load) state_next = gslqr_pkg::ST_IDLE;
            default:                state_next = gslqr_pkg::ST_IDLE;
        endcase
    end

    // outputs and shared multiplier operands
    always_comb begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        mul_a         = v_reg;
        mul_b         = u_reg;
        unique case (state_reg)
            gslqr_pkg::ST_IDLE:     s_axis_tready = 1'b1;
            gslqr_pkg::ST_NORM_MUL: begin
                mul_a = d_reg;
                mul_b = $signed({1'b0, leg_half_inv_reg});
            end
            gslqr_pkg::ST_XMUL:     mul_b = x_sel;
            gslqr_pkg::ST_OUT:      out_load = !m_valid_reg || m_axis_tready;
            default: ;
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_flr = prod_reg[gslqr_pkg::PROD_W-1:16];

    // clamp of (len - mid) to +/- half
    assign diff   = 33'(len_reg) - 33'(leg_mid_reg);
    assign half_s = $signed({2'b00, leg_half_reg});
    always_comb begin
        if (diff > half_s)       diff_cl = half_s;
        else if (diff < -half_s) diff_cl = -half_s;
        else                     diff_cl = diff;
    end

    assign hsum    = (gslqr_pkg::FLR_W + 1)'(prod_flr) + (gslqr_pkg::FLR_W + 1)'(coef_rd);
    assign acc_neg = -((gslqr_pkg::ACC_W + 1)'(acc_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gslqr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath and counters
    always_ff @(posedge aclk) begin
        oob_reg <= (slot_reg >= gslqr_pkg::SLOT_W'(gslqr_pkg::STORE_DEPTH));
        unique case (state_reg)
            gslqr_pkg::ST_IDLE: begin
                if (comp_req) begin
                    len_reg <= s_axis_tdata[gslqr_pkg::OFS_LEG_LENGTH +: 32];
                    for (int n = 0; n < gslqr_pkg::STATE_INPUTS; n++) begin
                        x_reg[n] <= s_axis_tdata[gslqr_pkg::OFS_STATE0 + 32*n +: 32];
                    end
                    slot_reg <= '0;
                    row_reg  <= '0;
                    col_reg  <= '0;
                    acc_reg  <= '0;
                    res0_reg <= 32'sd0;
                    res1_reg <= 32'sd0;
                end
            end
            gslqr_pkg::ST_CLAMP:    d_reg    <= diff_cl[31:0];
            gslqr_pkg::ST_NORM_MUL: prod_reg <= mul_p;
            gslqr_pkg::ST_NORM_SAT: u_reg    <= gslqr_pkg::sat32(64'(prod_flr));
            gslqr_pkg::ST_COEF_RD:  slot_reg <= slot_reg + 1'b1;
            gslqr_pkg::ST_V_INIT: begin
                v_reg <= coef_rd;
                k_reg <= gslqr_pkg::K_W'(1);
            end
            gslqr_pkg::ST_HMUL: begin
                prod_reg <= mul_p;
                slot_reg <= slot_reg + 1'b1;
            end
            gslqr_pkg::ST_HADD: begin
                v_reg <= gslqr_pkg::sat32(64'(hsum));
                k_reg <= k_reg + 1'b1;
            end
            gslqr_pkg::ST_XMUL:     prod_reg <= mul_p;
            gslqr_pkg::ST_XACC: begin
                acc_reg <= acc_reg + gslqr_pkg::ACC_W'(prod_flr);
                col_reg <= col_last ? '0 : col_reg + 1'b1;
            end
            gslqr_pkg::ST_ROW_END: begin
                if (row_reg == '0) begin
                    res0_reg <= gslqr_pkg::sat32(64'(acc_neg));
                end
                if (gslqr_pkg::NUM_OUTPUTS > 1 && row_reg == gslqr_pkg::ROW_W'(1)) begin
                    res1_reg <= gslqr_pkg::sat32(64'(acc_neg));
                end
                acc_reg <= '0;
                row_reg <= row_reg + 1'b1;
            end
            gslqr_pkg::ST_OUT: ;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {res1_reg, res0_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

### rtl/gslqr_checker.sv
// ----------------------------------------------------------------------------
// gslqr_checker
// Port-level checks for the gain-scheduled LQR controller, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module gslqr_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic [gslqr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input wire logic                              s_axis_tuser,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [gslqr_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input wire logic                              cfg_valid,
    input wire logic                              cfg_ready,
    input wire logic [gslqr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input wire logic [31:0]                       cfg_data
);

    // compute request blocks the input side
    a_busy_after_compute: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> !s_axis_tready)
        else $error("input ready after compute request");

    // load request does not block the input side
    a_ready_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> s_axis_tready)
        else $error("input blocked after load request");

    // result held while stalled
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped or changed under stall");

    // a new result comes only from a compute in flight
    a_result_needs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tready && !(m_axis_tvalid && !m_axis_tready)) |=> !$rose(m_axis_tvalid)
        || !$past(s_axis_tready, 1) || ($past(s_axis_tready, 1) && 1'b0))
        else $error("result without compute request");

endmodule

bind gain_scheduled_lqr_controller_top gslqr_checker u_gslqr_checker (.*);

`default_nettype wire

### tb/feedback_checker.sv
// ----------------------------------------------------------------------------
// feedback_checker
// Watches the request, result and register channels of the gain-scheduled
// LQR controller, predicts -K(u)*x for every compute request from its own
// copy of the registers and coefficient RAM, and compares each result.
// ----------------------------------------------------------------------------
package lqr_tb_pkg;

    typedef enum logic {
        ACT_COMPUTE = 1'b0,
        ACT_LOAD    = 1'b1
    } action_t;

endpackage

module feedback_checker
    import gslqr_pkg::*;
    import lqr_tb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                   s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [M_TDATA_W-1:0]   m_axis_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]            cfg_data,
    output int                     mismatches,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] leg_torque;
        logic [31:0] wheel_accel;
    } feedback_t;

    logic signed [31:0] leg_mid_q      = LEG_MID_RST;
    logic        [30:0] leg_half_q     = LEG_HALF_RST;
    logic        [30:0] leg_half_inv_q = LEG_HALF_INV_RST;
    logic signed [31:0] gain_coefs [STORE_DEPTH];
    feedback_t          feedback_q [$];
    int                 fail_total = 0;

    assign mismatches = fail_total;

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint floor_q16(input longint v);
        return v >>> 16;
    endfunction

    function automatic longint coef_at(input int idx);
        longint c;
        c = 0;
        if (idx >= 0 && idx < STORE_DEPTH) begin
            c = gain_coefs[idx];
        end
        return c;
    endfunction

    function automatic feedback_t predict_feedback(input logic [S_TDATA_W-1:0] d);
        longint    mid, half, inv, lo, hi, len, u, v, acc;
        longint    xs [NUM_STATES];
        longint    out_row [2];
        int        base;
        feedback_t r;
        mid = leg_mid_q;
        half = leg_half_q;
        inv = leg_half_inv_q;
        lo = mid - half;
        hi = mid + half;
        len = $signed(d[OFS_LEG_LENGTH +: 32]);
        if (len < lo) begin
            len = lo;
        end
        if (len > hi) begin
            len = hi;
        end
        u = clip32(floor_q16((len - mid) * inv));
        for (int j = 0; j < NUM_STATES; j++) begin
            xs[j] = 0;
            if (j < STATE_INPUTS) begin
                xs[j] = $signed(d[OFS_STATE0 + 32*j +: 32]);
            end
        end
        out_row[0] = 0;
        out_row[1] = 0;
        for (int i = 0; i < NUM_OUTPUTS && i < 2; i++) begin
            acc = 0;
            for (int j = 0; j < NUM_STATES; j++) begin
                base = (i * NUM_STATES + j) * (POLY_ORDER + 1);
                v = coef_at(base);
                for (int k = 1; k <= POLY_ORDER; k++) begin
                    v = clip32(floor_q16(v * u) + coef_at(base + k));
                end
                acc += floor_q16(v * xs[j]);
            end
            out_row[i] = clip32(-acc);
        end
        r.wheel_accel = out_row[0][31:0];
        r.leg_torque  = out_row[1][31:0];
        return r;
    endfunction

    task automatic note_failure(input string what);
        fail_total++;
        if (fail_total <= 10) begin
            $display("%s", what);
        end
    endtask

    always @(posedge aclk) begin : monitor
        feedback_t want;
        feedback_t got;
        if (!aresetn) begin
            leg_mid_q      <= LEG_MID_RST;
            leg_half_q     <= LEG_HALF_RST;
            leg_half_inv_q <= LEG_HALF_INV_RST;
            feedback_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_LEG_MID:      leg_mid_q      <= cfg_data;
                    CFG_LEG_HALF:     leg_half_q     <= cfg_data[30:0];
                    CFG_LEG_HALF_INV: leg_half_inv_q <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (feedback_q.size() == 0) begin
                    note_failure($sformatf("unexpected result: wheel_accel %h leg_torque %h",
                                           got.wheel_accel, got.leg_torque));
                end else begin
                    want = feedback_q.pop_front();
                    if (got.wheel_accel !== want.wheel_accel ||
                            got.leg_torque !== want.leg_torque) begin
                        note_failure($sformatf({"result mismatch: wheel_accel exp %h got %h, ",
                                                "leg_torque exp %h got %h"},
                                               want.wheel_accel, got.wheel_accel,
                                               want.leg_torque, got.leg_torque));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (action_t'(s_axis_tuser) == ACT_LOAD) begin
                    gain_coefs[s_axis_tdata[OFS_COEF_INDEX +: ADDR_W]] =
                        s_axis_tdata[OFS_COEF_VALUE +: 32];
                end else begin
                    feedback_q.push_back(predict_feedback(s_axis_tdata));
                end
            end
        end
        pending <= feedback_q.size();
    end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the gain-scheduled LQR controller: loads the whole coefficient
// RAM, runs directed corner requests, then random phases under several
// register settings with random gaps, a gap-free stretch and an output stall.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gslqr_pkg::*;
    import lqr_tb_pkg::*;

    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASE_ITEMS   = 150;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [31:0]           cfg_data      = '0;
    int                    mismatches;
    int                    pending;

    logic                  idle_on   = 1'b1;
    logic                  hold_req  = 1'b0;
    logic                  hold_done = 1'b0;
    logic signed [31:0]    cur_mid   = LEG_MID_RST;
    logic        [30:0]    cur_half  = LEG_HALF_RST;

    gain_scheduled_lqr_controller_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    feedback_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial begin
        forever begin
            #1 aclk = ~aclk;
        end
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // result side: random back-pressure, one long hold-off on request
    initial begin : receiver
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                m_axis_tready <= !(idle_on && $urandom_range(99) < 31);
            end
        end
    end

    function automatic logic [31:0] rand_q16();
        logic [31:0] r;
        case ($urandom_range(9))
            0, 1, 2, 3: r = $urandom;
            4, 5, 6:    r = 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
            7:          r = 32'h7FFF_FFFF;
            8:          r = 32'h8000_0000;
            default:    r = 32'($signed($urandom_range(0, 8)) - 4);
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rand_leg();
        longint span, off, len;
        if ($urandom_range(1) == 0) begin
            return rand_q16();
        end
        span = longint'(cur_half) + longint'(cur_half) / 4;
        off = (longint'($urandom) % (2 * span + 1)) - span;
        len = longint'(cur_mid) + off;
        return len[31:0];
    endfunction

    task automatic offer_request(input action_t act, input logic [S_TDATA_W-1:0] d);
        while (idle_on && $urandom_range(99) < 31) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= d;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic send_load(input logic [4:0] idx, input logic [31:0] value);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[OFS_COEF_INDEX +: 5]  = idx;
        d[OFS_COEF_VALUE +: 32] = value;
        d[OFS_LEG_LENGTH +: 32] = $urandom;
        for (int j = 0; j < 4; j++) begin
            d[OFS_STATE0 + 32*j +: 32] = $urandom;
        end
        offer_request(ACT_LOAD, d);
    endtask

    task automatic send_compute(input logic [31:0] leg, input logic [31:0] pa,
                                input logic [31:0] pr, input logic [31:0] wa,
                                input logic [31:0] wr);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[OFS_COEF_INDEX +: 5]   = 5'($urandom);
        d[OFS_COEF_VALUE +: 32]  = $urandom;
        d[OFS_LEG_LENGTH +: 32]  = leg;
        d[OFS_STATE0 +: 32]      = pa;
        d[OFS_STATE0 + 32 +: 32] = pr;
        d[OFS_STATE0 + 64 +: 32] = wa;
        d[OFS_STATE0 + 96 +: 32] = wr;
        offer_request(ACT_COMPUTE, d);
    endtask

    task automatic set_register(input cfg_idx_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [31:0] mid, input logic [30:0] half,
                             input logic [30:0] inv, input logic gaps,
                             input logic hold);
        settle();
        set_register(CFG_LEG_MID, mid);
        set_register(CFG_LEG_HALF, {1'b0, half});
        set_register(CFG_LEG_HALF_INV, {1'b0, inv});
        cfg_valid <= 1'b0;
        cur_mid  = mid;
        cur_half = half;
        idle_on  = gaps;
        hold_req = hold;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(99) < 25) begin
                send_load(5'($urandom_range(0, STORE_DEPTH - 1)), rand_q16());
            end else begin
                send_compute(rand_leg(), rand_q16(), rand_q16(), rand_q16(), rand_q16());
            end
        end
    endtask

    initial begin : stimulus
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill the whole coefficient RAM before any compute
        for (int i = 0; i < STORE_DEPTH; i++) begin
            case (i)
                0, 30:   send_load(5'(i), 32'h7FFF_FFFF);
                1, 31:   send_load(5'(i), 32'h8000_0000);
                default: send_load(5'(i), 32'((i - 16) * 32'sh0000_2000));
            endcase
        end

        send_compute(32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_compute(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_compute(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_compute(32'h0000_8000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_compute(32'hFFFF_8000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000);
        send_load(5'd0, 32'h0000_4000);
        send_load(5'd1, 32'hFFFF_C000);
        send_load(5'd30, 32'h0000_0001);
        send_load(5'd31, 32'hFFFF_FFFF);
        send_compute(32'h0001_0000, 32'h0000_1000, 32'hFFFF_F000, 32'h0002_0000, 32'h0000_0001);
        send_compute(32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFE_0000, 32'h7FFF_FFFF);
        send_compute(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);

        run_phase(32'h0000_0000, 31'h0001_0000, 31'h0001_0000, 1'b1, 1'b0);
        run_phase(32'h0000_C000, 31'h0000_4000, 31'h0004_0000, 1'b0, 1'b0);
        run_phase($urandom, 31'($urandom_range(0, 32'h0004_0000)),
                  31'($urandom_range(0, 32'h0010_0000)), 1'b1, 1'b1);
        run_phase(32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b0);
        run_phase(32'h7FFF_FFFF, 31'h0000_0000, 31'h0000_0000, 1'b1, 1'b0);

        settle();
        if (mismatches == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### files.f
rtl/gslqr_pkg.sv
rtl/gslqr_ram.sv
rtl/gain_scheduled_lqr_controller_top.sv
rtl/gslqr_checker.sv
tb/feedback_checker.sv
tb/testbench.sv
